/* hdl/sff_pkg.sv */
// Shared types, constants and helpers of the substring first/last finder.
package sff_pkg;

  // Pattern storage and window geometry.
  localparam int PATTERN_BYTES = 16;
  localparam int CELLS         = PATTERN_BYTES - 1;
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
  localparam int PIDX_W        = $clog2(PATTERN_BYTES);
  localparam int CFG_W         = 64;
  localparam int IDX_W         = 2;

  // Text position range.
  localparam int START_W        = 16;
  localparam int POS_W          = START_W + 1;
  localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(65536);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SEARCH_MODE  = 2'd3;

  // Search mode codes.
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_LAST  = 1'b1;

  // Control shared by every cell of the window.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Per-transfer control for the match tracker.
  typedef struct packed {
    logic accept;
    logic last;
    logic match;
  } track_ctrl_t;

  // Select pattern byte idx from the packed pattern, byte 0 in the low bits.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [2*CFG_W-1:0] pat,
                                                     input logic [PIDX_W-1:0] idx);
    pattern_byte = pat[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

/* hdl/sff_text_if.sv */
// Input channel carrying one text byte per transfer.
interface sff_text_if;
  logic                      valid;
  logic                      ready;
  logic [sff_pkg::BYTE_W-1:0] text_byte;
  logic                      end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* hdl/sff_result_if.sv */
// Output channel carrying one search result per text.
interface sff_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sff_pkg::START_W-1:0] match_start;
  logic                        text_too_long;

  modport source (output valid, output found, output match_start, output text_too_long,
                  input ready);
  modport sink   (input valid, input found, input match_start, input text_too_long,
                  output ready);
endinterface

/* hdl/sff_cell.sv */
// One window cell: holds a recent text byte and compares it with a pattern byte.
module sff_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  sff_pkg::cell_ctrl_t         ctrl,
  input  logic [sff_pkg::BYTE_W-1:0]  byte_in,
  input  logic                        valid_in,
  input  logic [sff_pkg::BYTE_W-1:0]  pattern,
  input  logic                        needed,
  output logic [sff_pkg::BYTE_W-1:0]  byte_out,
  output logic                        valid_out,
  output logic                        ok
);

  logic [sff_pkg::BYTE_W-1:0] held;
  logic                       held_valid;

  // The byte is payload; it moves to the neighbor on every transfer.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  // The valid bit marks a byte of the current text.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= valid_in;
    end
  end

  // A cell outside the pattern length never blocks a match.
  assign ok        = !needed || (held_valid && (held == pattern));
  assign byte_out  = held;
  assign valid_out = held_valid;

endmodule

/* hdl/sff_tracker.sv */
// Position counter, occurrence record and result output register.
module sff_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  sff_pkg::track_ctrl_t       ctrl,
  input  logic [sff_pkg::LEN_W-1:0]  pattern_length,
  input  logic                       search_mode,
  output logic                       in_ready,
  sff_result_if.source               result
);

  logic [sff_pkg::POS_W-1:0]   position, position_next;
  logic                        have_match, have_match_next;
  logic [sff_pkg::START_W-1:0] recorded_start, recorded_start_next;
  logic                        overflow_seen, overflow_seen_next;
  logic                        res_valid;
  logic                        res_found;
  logic [sff_pkg::START_W-1:0] res_start;
  logic                        res_too_long;
  logic                        over;
  logic [sff_pkg::START_W-1:0] start;

  // A waiting result only blocks input when the receiver stalls.
  assign in_ready = !res_valid || result.ready;

  assign over  = (position >= sff_pkg::TEXT_LIMIT);
  assign start = position[sff_pkg::START_W-1:0] + sff_pkg::START_W'(1)
                 - sff_pkg::START_W'(pattern_length);

  // Per-text state update for one transfer.
  always_comb begin
    position_next       = position;
    have_match_next     = have_match;
    recorded_start_next = recorded_start;
    overflow_seen_next  = overflow_seen;
    if (ctrl.accept) begin
      if (over) begin
        overflow_seen_next = 1'b1;
      end else if (ctrl.match &&
                   (search_mode == sff_pkg::MODE_LAST || !have_match)) begin
        recorded_start_next = start;
        have_match_next     = 1'b1;
      end
      if (!over) begin
        position_next = position + sff_pkg::POS_W'(1);
      end
    end
  end

  // Per-text registers, cleared after the final byte.
  always_ff @(posedge clk) begin
    if (rst || (ctrl.accept && ctrl.last)) begin
      position       <= '0;
      have_match     <= 1'b0;
      recorded_start <= '0;
      overflow_seen  <= 1'b0;
    end else begin
      position       <= position_next;
      have_match     <= have_match_next;
      recorded_start <= recorded_start_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.accept && ctrl.last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded from the state after the final byte.
  always_ff @(posedge clk) begin
    if (ctrl.accept && ctrl.last) begin
      res_found    <= have_match_next;
      res_start    <= have_match_next ? recorded_start_next : '0;
      res_too_long <= overflow_seen_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.found         = res_found;
  assign result.match_start   = res_start;
  assign result.text_too_long = res_too_long;

  // The final byte of a text always yields a result next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (ctrl.accept && ctrl.last) |=> res_valid)
    else $error("final byte did not produce a result");

  // A new text starts counting at zero.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (ctrl.accept && ctrl.last) |=> (position == '0 && !have_match && !overflow_seen))
    else $error("per-text state not cleared");

  // The position counter saturates at the text limit.
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= sff_pkg::TEXT_LIMIT)
    else $error("position beyond text limit");

  // An absent occurrence reports a zero start.
  a_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_start == '0))
    else $error("nonzero start without a match");

  // A stalled input must not be taken while the result waits.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !result.ready) |-> !ctrl.accept)
    else $error("input taken while result stalled");

endmodule

/* hdl/substring_first_last_finder_unit.sv */
// Top level of the streaming substring finder with first/last occurrence tracking.
//
// The text channel takes one byte per transfer with an end_of_text flag on the
// final byte. The result channel gives one transfer per text: found, the
// zero-based match_start and text_too_long. The pattern (up to 16 bytes), its
// length and the search mode are set through the write port, register index
// 0 pattern low bytes, 1 pattern high bytes, 2 length, 3 mode. The user must
// set them only while idle; the block does not enforce this. The text channel
// takes one byte per cycle. A row of 15 window cells shifts the recent bytes
// on every transfer and compares them in parallel with the pattern, so the
// match decision for a byte is made in the cycle it arrives. The result
// appears in the cycle after the final byte. When the receiver stalls, the
// result is held in the output register and the text channel takes no byte
// until that result has transferred. A synchronous reset clears the
// configuration to zero, empties the window, and drops any pending result.
module substring_first_last_finder_unit (
  input  logic                          clk,
  input  logic                          rst,
  sff_text_if.sink                      text,
  sff_result_if.source                  result,
  input  logic                          write_enable,
  input  logic [sff_pkg::IDX_W-1:0]     write_index,
  input  logic [sff_pkg::CFG_W-1:0]     write_data
);

  logic [sff_pkg::CFG_W-1:0]   pattern_low;
  logic [sff_pkg::CFG_W-1:0]   pattern_high;
  logic [sff_pkg::LEN_W-1:0]   pattern_length;
  logic                        search_mode;
  logic [2*sff_pkg::CFG_W-1:0] pattern;

  sff_pkg::cell_ctrl_t         cell_ctrl;
  sff_pkg::track_ctrl_t        track_ctrl;
  logic                        accept;
  logic                        in_ready;
  logic                        len_ok;
  logic                        head_ok;
  logic                        match;

  logic [sff_pkg::BYTE_W-1:0]  cell_byte  [sff_pkg::CELLS];
  logic [sff_pkg::CELLS-1:0]   cell_valid;
  logic [sff_pkg::CELLS-1:0]   cell_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      search_mode    <= sff_pkg::MODE_FIRST;
    end else if (write_enable) begin
      case (write_index)
        sff_pkg::REG_PATTERN_LOW:  pattern_low    <= write_data;
        sff_pkg::REG_PATTERN_HIGH: pattern_high   <= write_data;
        sff_pkg::REG_PATTERN_LEN:  pattern_length <= write_data[sff_pkg::LEN_W-1:0];
        sff_pkg::REG_SEARCH_MODE:  search_mode    <= write_data[0];
        default: ;
      endcase
    end
  end

  assign pattern = {pattern_high, pattern_low};

  // Transfer and cell control.
  assign text.ready      = in_ready;
  assign accept          = text.valid && in_ready;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && text.end_of_text;

  // Window cells; cell j holds the byte j+1 places before the current one.
  for (genvar j = 0; j < sff_pkg::CELLS; j++) begin : g_cell
    logic [sff_pkg::BYTE_W-1:0] byte_in;
    logic                       valid_in;
    logic                       needed;
    logic [sff_pkg::BYTE_W-1:0] pat_sel;

    if (j == 0) begin : g_head
      assign byte_in  = text.text_byte;
      assign valid_in = 1'b1;
    end else begin : g_link
      assign byte_in  = cell_byte[j-1];
      assign valid_in = cell_valid[j-1];
    end

    assign needed  = (pattern_length > sff_pkg::LEN_W'(j + 1));
    assign pat_sel = sff_pkg::pattern_byte(pattern,
                       sff_pkg::PIDX_W'(pattern_length - sff_pkg::LEN_W'(j + 2)));

    sff_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .byte_in   (byte_in),
      .valid_in  (valid_in),
      .pattern   (pat_sel),
      .needed    (needed),
      .byte_out  (cell_byte[j]),
      .valid_out (cell_valid[j]),
      .ok        (cell_ok[j])
    );
  end

  // The current byte must equal the last pattern byte.
  assign len_ok  = (pattern_length != '0) &&
                   (pattern_length <= sff_pkg::LEN_W'(sff_pkg::PATTERN_BYTES));
  assign head_ok = (text.text_byte == sff_pkg::pattern_byte(pattern,
                     sff_pkg::PIDX_W'(pattern_length - sff_pkg::LEN_W'(1))));
  assign match   = len_ok && head_ok && (&cell_ok);

  assign track_ctrl.accept = accept;
  assign track_ctrl.last   = text.end_of_text;
  assign track_ctrl.match  = match;

  sff_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (track_ctrl),
    .pattern_length (pattern_length),
    .search_mode    (search_mode),
    .in_ready       (in_ready),
    .result         (result)
  );

  // Cell valid bits fill from the head of the row without gaps.
  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid[sff_pkg::CELLS-1:1] & ~cell_valid[sff_pkg::CELLS-2:0]) == '0))
    else $error("window valid bits not contiguous");

  // A match never uses a byte from before the current text.
  a_match_in_window: assert property (@(posedge clk) disable iff (rst)
    (match && pattern_length > sff_pkg::LEN_W'(1)) |->
      cell_valid[sff_pkg::PIDX_W'(pattern_length - sff_pkg::LEN_W'(2))])
    else $error("match reaches outside the window");

  // The window is empty after the final byte of a text.
  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && text.end_of_text) |=> (cell_valid == '0))
    else $error("window not cleared after final byte");

endmodule

/* tb/substring_first_last_finder_unit_tb.sv */
// Self-checking testbench of the substring finder: scripted texts, random stalls, report checks.
module substring_first_last_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sff_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int QUIET_CYCLES    = 4;
  localparam int CALM_TAIL       = 200;
  localparam int RANDOM_ITEMS    = 1600;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TEXT_END        = int'(TEXT_LIMIT);
  localparam int LONG_TEXT_BYTES = TEXT_END + 48;

  typedef enum logic {OP_BYTE, OP_WRITE} op_kind_t;

  // One step of the stimulus script: a text byte or a register write.
  typedef struct {
    op_kind_t               kind;
    logic [IDX_W-1:0]       index;
    logic [CFG_W-1:0]       data;
    logic [BYTE_W-1:0]      text_byte;
    logic                   end_of_text;
    bit                     steady;
  } script_op_t;

  typedef struct packed {
    logic                 found;
    logic [START_W-1:0]   match_start;
    logic                 text_too_long;
  } search_report_t;

  typedef struct packed {
    logic [2*CFG_W-1:0]   pattern;
    logic [LEN_W-1:0]     length;
    logic                 mode;
  } finder_setup_t;

  logic               clk;
  logic               rst;
  logic               write_enable;
  logic [IDX_W-1:0]   write_index;
  logic [CFG_W-1:0]   write_data;

  sff_text_if   text_ch();
  sff_result_if result_ch();

  substring_first_last_finder_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .text         (text_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  // Scripted stimulus and the reports the finder owes.
  script_op_t     text_script [$];
  search_report_t pending_reports [$];

  // Register image seen by the finder and the one the script generator tracks.
  finder_setup_t live_setup = '0;
  finder_setup_t plan_setup = '0;

  // Per-text search state of the predictor.
  logic [BYTE_W-1:0]  history [PATTERN_BYTES];
  int                 history_fill;
  int                 text_pos;
  bit                 match_held;
  logic [START_W-1:0] match_origin;
  bit                 overflow_held;

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int quiet_count    = 0;

  function automatic void apply_write(inout finder_setup_t setup, input logic [IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
    case (idx)
      REG_PATTERN_LOW:  setup.pattern[CFG_W-1:0]       = data;
      REG_PATTERN_HIGH: setup.pattern[2*CFG_W-1:CFG_W] = data;
      REG_PATTERN_LEN:  setup.length                   = data[LEN_W-1:0];
      REG_SEARCH_MODE:  setup.mode                     = data[0];
      default: ;
    endcase
  endfunction

  function automatic void clear_text_state();
    foreach (history[i]) history[i] = '0;
    history_fill  = 0;
    text_pos      = 0;
    match_held    = 1'b0;
    match_origin  = '0;
    overflow_held = 1'b0;
  endfunction

  // Advance the search by one accepted byte; a final byte yields a report.
  function automatic void scan_text_byte(input logic [BYTE_W-1:0] cur, input logic closing);
    int             len;
    bit             hit;
    search_report_t report;
    len = int'(live_setup.length);
    if (text_pos >= TEXT_END) begin
      overflow_held = 1'b1;
    end else begin
      hit = 1'b0;
      if (len >= 1 && len <= PATTERN_BYTES && history_fill >= len - 1) begin
        hit = (live_setup.pattern[(len-1)*BYTE_W +: BYTE_W] == cur);
        for (int k = 1; k < len; k++) begin
          if (live_setup.pattern[(len-1-k)*BYTE_W +: BYTE_W] != history[k-1]) hit = 1'b0;
        end
      end
      if (hit && (live_setup.mode == MODE_LAST || !match_held)) begin
        match_origin = START_W'(text_pos + 1 - len);
        match_held   = 1'b1;
      end
    end
    for (int k = PATTERN_BYTES - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = cur;
    if (history_fill < CELLS) history_fill++;
    if (text_pos < TEXT_END) text_pos++;
    if (closing) begin
      report.found         = match_held;
      report.match_start   = match_held ? match_origin : '0;
      report.text_too_long = overflow_held;
      pending_reports.push_back(report);
      clear_text_state();
    end
  endfunction

  function automatic void add_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    script_op_t op;
    op = '{kind: OP_WRITE, index: idx, data: data, text_byte: '0, end_of_text: 1'b0,
           steady: 1'b0};
    text_script.push_back(op);
    apply_write(plan_setup, idx, data);
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic closing,
                                   input bit steady);
    script_op_t op;
    op = '{kind: OP_BYTE, index: '0, data: '0, text_byte: b, end_of_text: closing,
           steady: steady};
    text_script.push_back(op);
  endfunction

  // Random register values; every = 1 writes all four registers, else one of them.
  function automatic void add_random_setting(input bit every);
    logic [CFG_W-1:0]  lo, hi, len_word, mode_word;
    logic [BYTE_W-1:0] sym_a, sym_b;
    int                pick, len;
    sym_a = BYTE_W'($urandom);
    sym_b = BYTE_W'($urandom);
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    // A two-symbol pattern gives plenty of overlapping occurrences.
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < CFG_W; i += BYTE_W) begin
        lo[i +: BYTE_W] = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
        hi[i +: BYTE_W] = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      end
    end
    case ($urandom_range(0, 15))
      0: begin lo = '0; hi = '0; end
      1: begin lo = '1; hi = '1; end
      default: ;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) len = 0;
    else if (pick == 1) len = $urandom_range(PATTERN_BYTES + 1, 31);
    else if (pick < 4) len = PATTERN_BYTES;
    else if (pick < 6) len = 1;
    else len = $urandom_range(2, PATTERN_BYTES - 1);
    // Upper bits of the short registers carry noise half of the time.
    len_word  = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
    len_word[LEN_W-1:0] = LEN_W'(len);
    mode_word = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
    mode_word[0] = ($urandom_range(0, 1) == 1) ? MODE_LAST : MODE_FIRST;
    if (every) begin
      add_write(REG_PATTERN_LOW, lo);
      add_write(REG_PATTERN_HIGH, hi);
      add_write(REG_PATTERN_LEN, len_word);
      add_write(REG_SEARCH_MODE, mode_word);
    end else begin
      case ($urandom_range(0, 3))
        0: add_write(REG_PATTERN_LOW, lo);
        1: add_write(REG_PATTERN_HIGH, hi);
        2: add_write(REG_PATTERN_LEN, len_word);
        default: add_write(REG_SEARCH_MODE, mode_word);
      endcase
    end
  endfunction

  // A text of n bytes with up to three copies of the current pattern planted in it.
  function automatic void add_text(input int n, input bit narrow);
    logic [BYTE_W-1:0] body [$];
    int                len, spot, cut;
    len = int'(plan_setup.length);
    for (int i = 0; i < n; i++) begin
      if (narrow)
        body.push_back(plan_setup.pattern[$urandom_range(0, PATTERN_BYTES-1)*BYTE_W +: BYTE_W]);
      else
        body.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    if (len >= 1 && len <= PATTERN_BYTES && len <= n) begin
      repeat ($urandom_range(0, 3)) begin
        spot = $urandom_range(0, n - len);
        for (int j = 0; j < len; j++) body[spot+j] = plan_setup.pattern[j*BYTE_W +: BYTE_W];
      end
    end
    // Now and then a register changes in the middle of the text.
    cut = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      if (cut != 0 && i == cut) add_random_setting(1'b0);
      add_byte(body[i], i == n - 1, 1'b0);
    end
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Text driver: presents scripted bytes, performs register writes when quiet.
  always @(posedge clk) begin : drive_text
    script_op_t        op;
    logic              v_n;
    logic [BYTE_W-1:0] b_n;
    logic              e_n;
    logic              we_n;
    logic [IDX_W-1:0]  wi_n;
    logic [CFG_W-1:0]  wd_n;
    if (rst) begin
      text_ch.valid       <= 1'b0;
      text_ch.text_byte   <= '0;
      text_ch.end_of_text <= 1'b0;
      write_enable        <= 1'b0;
      write_index         <= '0;
      write_data          <= '0;
      gap_left            = 0;
      quiet_count         = 0;
    end else begin
      v_n  = text_ch.valid;
      b_n  = text_ch.text_byte;
      e_n  = text_ch.end_of_text;
      we_n = 1'b0;
      wi_n = write_index;
      wd_n = write_data;
      if (text_ch.valid && text_ch.ready) begin
        scan_text_byte(text_ch.text_byte, text_ch.end_of_text);
        v_n = 1'b0;
      end
      if (pending_reports.size() == 0 && !text_ch.valid && !result_ch.valid && !write_enable)
        quiet_count++;
      else
        quiet_count = 0;
      if (!v_n && text_script.size() != 0) begin
        op = text_script[0];
        if (op.kind == OP_WRITE) begin
          // Registers change only once every report is in and the window has settled.
          if (quiet_count >= QUIET_CYCLES) begin
            we_n = 1'b1;
            wi_n = op.index;
            wd_n = op.data;
            apply_write(live_setup, op.index, op.data);
            void'(text_script.pop_front());
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (!op.steady && text_script.size() > CALM_TAIL &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 17) - 1;
        end else begin
          v_n = 1'b1;
          b_n = op.text_byte;
          e_n = op.end_of_text;
          void'(text_script.pop_front());
        end
      end
      text_ch.valid       <= v_n;
      text_ch.text_byte   <= b_n;
      text_ch.end_of_text <= e_n;
      write_enable        <= we_n;
      write_index         <= wi_n;
      write_data          <= wd_n;
    end
  end

  // Result monitor: checks each transfer against the oldest pending report.
  always @(posedge clk) begin : watch_results
    search_report_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual found %0d start %0d long %0d",
                   $time, result_ch.found, result_ch.match_start, result_ch.text_too_long);
        end else begin
          want = pending_reports.pop_front();
          if (result_ch.found !== want.found) begin
            mismatch_count++;
            $display("%0t: found mismatch, expected %0d actual %0d",
                     $time, want.found, result_ch.found);
          end
          if (result_ch.match_start !== want.match_start) begin
            mismatch_count++;
            $display("%0t: match_start mismatch, expected %0d actual %0d",
                     $time, want.match_start, result_ch.match_start);
          end
          if (result_ch.text_too_long !== want.text_too_long) begin
            mismatch_count++;
            $display("%0t: text_too_long mismatch, expected %0d actual %0d",
                     $time, want.text_too_long, result_ch.text_too_long);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (text_script.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Script construction, reset and end of run.
  initial begin : run_script
    int                items;
    int                n;
    int                long_len;
    bit                long_done;
    logic [BYTE_W-1:0] b;
    rst                 = 1'b1;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.end_of_text = 1'b0;
    result_ch.ready     = 1'b0;
    write_enable        = 1'b0;
    write_index         = '0;
    write_data          = '0;
    clear_text_state();

    // Empty pattern straight after reset never matches.
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    // One-byte pattern against one-byte texts.
    add_write(REG_PATTERN_LOW, 64'h8877_6655_4433_22FF);
    add_write(REG_PATTERN_HIGH, 64'h00F0_E1D2_C3B4_A596);
    add_write(REG_PATTERN_LEN, 64'd1);
    add_write(REG_SEARCH_MODE, CFG_W'(MODE_FIRST));
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    // Full-length pattern ending on the final byte.
    add_write(REG_PATTERN_LEN, CFG_W'(PATTERN_BYTES));
    add_write(REG_SEARCH_MODE, CFG_W'(MODE_LAST));
    for (int i = 0; i < PATTERN_BYTES; i++)
      add_byte(plan_setup.pattern[i*BYTE_W +: BYTE_W], i == PATTERN_BYTES - 1, 1'b0);
    // Overlapping occurrences, last then first.
    add_write(REG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
    add_write(REG_PATTERN_LEN, 64'd2);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b1, 1'b0);
    add_write(REG_SEARCH_MODE, CFG_W'(MODE_FIRST));
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b0, 1'b0);
    add_byte(8'hAA, 1'b1, 1'b0);

    // Random phases of settings and texts, with one text past the index range.
    items     = 0;
    long_done = 1'b0;
    while (items < RANDOM_ITEMS) begin
      add_random_setting(1'b1);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 9))
          0: n = 1;
          1: n = $urandom_range(40, 120);
          default: n = $urandom_range(2, 32);
        endcase
        add_text(n, $urandom_range(0, 1) == 1);
        items += n;
      end
      if (!long_done && items >= RANDOM_ITEMS / 2) begin
        long_done = 1'b1;
        add_write(REG_PATTERN_LEN, CFG_W'($urandom_range(1, PATTERN_BYTES)));
        add_write(REG_SEARCH_MODE, CFG_W'(MODE_LAST));
        long_len = int'(plan_setup.length);
        // One copy ends on the last indexable byte, one lies past the range.
        for (int p = 0; p < LONG_TEXT_BYTES; p++) begin
          if (p >= TEXT_END - long_len && p < TEXT_END)
            b = plan_setup.pattern[(p - TEXT_END + long_len)*BYTE_W +: BYTE_W];
          else if (p > TEXT_END && p <= TEXT_END + long_len)
            b = plan_setup.pattern[(p - TEXT_END - 1)*BYTE_W +: BYTE_W];
          else
            b = BYTE_W'($urandom_range(0, 255));
          add_byte(b, p == LONG_TEXT_BYTES - 1, p < TEXT_END - 64);
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    while (text_script.size() != 0 || text_ch.valid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_reports.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d reports never arrived", $time, pending_reports.size());
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/sff_pkg.sv
hdl/sff_text_if.sv
hdl/sff_result_if.sv
hdl/sff_cell.sv
hdl/sff_tracker.sv
hdl/substring_first_last_finder_unit.sv
tb/substring_first_last_finder_unit_tb.sv
